// ===== hw/rtl/ffpa_pkg.sv =====
// Package with shared types and constants for the first-fit pool allocator.
`timescale 1ns / 1ps
package ffpa_pkg;
    localparam int POOL_WORDS   = 1024;
    localparam int HEADER_WORDS = 1;
    localparam int WORD_BYTES   = 8;
    localparam int ADDR_W       = $clog2(POOL_WORDS);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int HDR_W        = CNT_W + 1;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_LARGEST = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [13:0] request_bytes;
        logic [9:0]  block_offset;
    } in_beat_t;

    typedef struct packed {
        logic [9:0] payload_offset;
        logic       status;
        logic [9:0] largest_words;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_CUR,
        ST_WT_CUR,
        ST_RD_NXT,
        ST_WT_NXT,
        ST_DECIDE,
        ST_SPLIT,
        ST_OUT
    } state_t;
endpackage

// ===== hw/rtl/first_fit_pool_allocator.sv =====
// Top level of the first-fit pool allocator: walk sequencer around a header RAM.
// Each beat is handled alone, and the next beat is taken once the result of the last one is in
// the output register. A free of a header reads that header and writes it back marked free. A
// free of an offset below the header size, or an unused code, goes straight to the output. An
// allocate or a query walks the headers from word 0, merging each free block with a free next
// block. An allocate takes the first free block that fits, and splits it when the rest can hold
// a header and a word. The hand-off to the output register waits while an earlier result is
// still unaccepted. A pool_words write taken while idle rewrites header word 0 in the same cycle.
`timescale 1ns / 1ps
module first_fit_pool_allocator
    import ffpa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data
);
    state_t state_reg, state_next;
    logic [CNT_W-1:0] pool_reg, pool_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] nxt_reg, nxt_next;
    logic [CNT_W-1:0] csize_reg, csize_next;
    logic cused_reg, cused_next;
    logic [CNT_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic is_alloc_reg, is_alloc_next;
    logic init_reg, init_next;
    out_beat_t res_reg, res_next;
    out_beat_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;

    logic ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [HDR_W-1:0] ram_wdata, ram_rdata;
    logic [CNT_W-1:0] cfg_pool;
    logic [CNT_W+1:0] rest_sum;
    logic [14:0] need_ext;

    ffpa_ram #(.WIDTH(HDR_W), .DEPTH(POOL_WORDS)) u_hdr (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (cfg_wdata > 11'(POOL_WORDS)) begin
            cfg_pool = CNT_W'(POOL_WORDS);
        end else if (cfg_wdata < 11'(HEADER_WORDS + 1)) begin
            cfg_pool = CNT_W'(HEADER_WORDS + 1);
        end else begin
            cfg_pool = CNT_W'(cfg_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pool_reg    <= CNT_W'(POOL_WORDS);
            init_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pool_reg    <= pool_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
        end
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_next;
        csize_reg    <= csize_next;
        cused_reg    <= cused_next;
        need_reg     <= need_next;
        best_reg     <= best_next;
        is_alloc_reg <= is_alloc_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE) && !init_reg && !cfg_we;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next    = state_reg;
        pool_next     = pool_reg;
        init_next     = 1'b0;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        csize_next    = csize_reg;
        cused_next    = cused_reg;
        need_next     = need_reg;
        best_next     = best_reg;
        is_alloc_next = is_alloc_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        ram_we        = 1'b0;
        ram_addr      = cur_reg;
        ram_wdata     = {1'b0, csize_reg};
        need_ext      = 15'(s_data.request_bytes) + 15'(WORD_BYTES - 1);
        rest_sum      = (CNT_W + 2)'(need_reg) + (CNT_W + 2)'(HEADER_WORDS + 1);

        case (state_reg)
            ST_IDLE: begin
                if (cfg_we || init_reg) begin
                    if (cfg_we) begin
                        pool_next = cfg_pool;
                        ram_wdata = {1'b0, cfg_pool - CNT_W'(HEADER_WORDS)};
                    end else begin
                        ram_wdata = {1'b0, pool_reg - CNT_W'(HEADER_WORDS)};
                    end
                    ram_we   = 1'b1;
                    ram_addr = '0;
                end else if (s_valid) begin
                    res_next  = '0;
                    cur_next  = '0;
                    best_next = '0;
                    need_next = CNT_W'(need_ext / 15'(WORD_BYTES));
                    if (need_ext / 15'(WORD_BYTES) > 15'(POOL_WORDS)) begin
                        need_next = CNT_W'(POOL_WORDS);
                    end
                    is_alloc_next = (s_data.func == FUNC_ALLOC);
                    case (func_t'(s_data.func))
                        FUNC_ALLOC, FUNC_LARGEST: state_next = ST_RD_CUR;
                        FUNC_FREE: begin
                            if (s_data.block_offset >= 10'(HEADER_WORDS)) begin
                                cur_next = ADDR_W'(s_data.block_offset - 10'(HEADER_WORDS));
                                state_next = ST_RD_CUR;
                                is_alloc_next = 1'b0;
                                need_next = '1;
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_RD_CUR: begin
                state_next = ST_WT_CUR;
            end
            ST_WT_CUR: begin
                csize_next = ram_rdata[CNT_W-1:0];
                cused_next = ram_rdata[CNT_W];
                if (need_reg == '1 && !is_alloc_reg) begin
                    ram_we     = 1'b1;
                    ram_wdata  = {1'b0, ram_rdata[CNT_W-1:0]};
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_RD_NXT;
                end
            end
            ST_RD_NXT: begin
                nxt_next = CNT_W'(cur_reg) + CNT_W'(HEADER_WORDS) + csize_reg;
                if (is_alloc_reg && !cused_reg && csize_reg >= need_reg) begin
                    state_next = ST_SPLIT;
                end else begin
                    state_next = ST_WT_NXT;
                end
                ram_addr = ADDR_W'(CNT_W'(cur_reg) + CNT_W'(HEADER_WORDS) + csize_reg);
            end
            ST_WT_NXT: begin
                ram_addr   = nxt_reg[ADDR_W-1:0];
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (nxt_reg >= pool_reg) begin
                    if (is_alloc_reg) begin
                        res_next.status = 1'b1;
                    end else begin
                        if (!cused_reg && csize_reg > best_reg) begin
                            best_next = csize_reg;
                        end
                        res_next.largest_words = (!cused_reg && csize_reg > best_reg)
                            ? csize_reg[9:0] : best_reg[9:0];
                    end
                    state_next = ST_OUT;
                end else if (!cused_reg && !ram_rdata[CNT_W]) begin
                    csize_next = csize_reg + ram_rdata[CNT_W-1:0] + CNT_W'(HEADER_WORDS);
                    ram_we     = 1'b1;
                    ram_wdata  = {1'b0, csize_next};
                    state_next = ST_RD_NXT;
                end else begin
                    if (!cused_reg && csize_reg > best_reg) begin
                        best_next = csize_reg;
                    end
                    cur_next   = nxt_reg[ADDR_W-1:0];
                    ram_addr   = nxt_reg[ADDR_W-1:0];
                    state_next = ST_WT_CUR;
                end
            end
            ST_SPLIT: begin
                if ((CNT_W + 2)'(csize_reg) >= rest_sum) begin
                    ram_addr  = ADDR_W'(CNT_W'(cur_reg) + CNT_W'(HEADER_WORDS) + need_reg);
                    ram_wdata = {1'b0, csize_reg - CNT_W'(HEADER_WORDS) - need_reg};
                    ram_we    = 1'b1;
                    csize_next = need_reg;
                    cused_next = 1'b1;
                    state_next = ST_SPLIT;
                    need_next  = csize_reg;
                    is_alloc_next = 1'b0;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, csize_reg};
                    res_next.payload_offset = 10'(CNT_W'(cur_reg) + CNT_W'(HEADER_WORDS));
                    state_next = ST_OUT;
                end
                if (!is_alloc_reg) begin
                    ram_we    = 1'b1;
                    ram_addr  = cur_reg;
                    ram_wdata = {1'b1, csize_reg};
                    res_next.payload_offset = 10'(CNT_W'(cur_reg) + CNT_W'(HEADER_WORDS));
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/ffpa_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module ffpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
